// ===== rtl/core/sliding_linear_regression_assert.svh =====
// Assertion helpers for the RTL that checks itself.
`ifndef SLIDING_LINEAR_REGRESSION_ASSERT_SVH
`define SLIDING_LINEAR_REGRESSION_ASSERT_SVH

// Clocked property, held off during reset.
`define SLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication onto the next cycle, held off during reset.
`define SLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/slr_pkg.sv =====
`default_nettype none
package slr_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int FRAC_BITS    = 16;

  localparam int WLEN_W = 7;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd22;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int IW = $clog2(MAX_WINDOW);

  localparam int OUT_W   = 32;
  localparam int R2_FRAC = 16;
  localparam int R2_W    = R2_FRAC + 1;
  localparam logic [R2_W-1:0] R2_ONE = {1'b1, {R2_FRAC{1'b0}}};

  localparam int SUMY_W  = SAMPLE_WIDTH + CW;
  localparam int SUMXY_W = SAMPLE_WIDTH + 2 * CW;
  localparam int SUMYY_W = 2 * SAMPLE_WIDTH + CW;
  localparam int SXYC_W  = SUMXY_W + CW + 1;
  localparam int SL_Q    = SXYC_W - 1;
  localparam int SYYC_W  = SUMYY_W + CW;
  localparam int T_W     = ((SAMPLE_WIDTH > OUT_W) ? SAMPLE_WIDTH : OUT_W) + 2 * CW + 2;
  localparam int ALU_W   = 2 * SXYC_W + R2_FRAC;
  localparam int NB_W    = $clog2(ALU_W + 1);

  localparam int SX_W = $clog2(MAX_WINDOW * (MAX_WINDOW - 1) / 2 + 1);
  localparam longint D_MAX = longint'(MAX_WINDOW) * MAX_WINDOW *
                             (longint'(MAX_WINDOW) * MAX_WINDOW - 1) / 12;
  localparam int D_W = $clog2(D_MAX + 1);

  typedef logic [SX_W-1:0] sx_tab_t [MAX_WINDOW+1];
  typedef logic [D_W-1:0]  d_tab_t  [MAX_WINDOW+1];

  // sum of positions 0..c-1
  function automatic sx_tab_t build_sx();
    sx_tab_t t;
    for (int i = 0; i <= MAX_WINDOW; i++) begin
      t[i] = SX_W'(i * (i - 1) / 2);
    end
    return t;
  endfunction

  // c*Sxx - Sx^2 = c^2 (c^2 - 1) / 12
  function automatic d_tab_t build_d();
    d_tab_t t;
    for (int i = 0; i <= MAX_WINDOW; i++) begin
      t[i] = D_W'(longint'(i) * i * (longint'(i) * i - 1) / 12);
    end
    return t;
  endfunction

  localparam sx_tab_t SX_TAB = build_sx();
  localparam d_tab_t  D_TAB  = build_d();

  typedef enum logic [0:0] {
    MD_MUL,
    MD_DIV
  } md_op_t;

  typedef struct packed {
    logic            start;
    md_op_t          op;
    logic [NB_W-1:0] nbits;
  } md_req_t;

  typedef struct packed {
    logic [CW-1:0] fill;
    logic [IW-1:0] wp;
  } win_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SETUP,
    S_ACC,
    S_SXYC,
    S_SXYC2,
    S_SLOPE,
    S_SLOPE_W,
    S_NUM,
    S_NUM_W,
    S_SY2,
    S_SY2_W,
    S_SYYC,
    S_DEN,
    S_DEN_W,
    S_R2,
    S_R2_W,
    S_RINIT,
    S_RES,
    S_RCHK,
    S_RDIV,
    S_RDIV_W,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/slr_window.sv =====
`default_nettype none
module slr_window
  import slr_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic                           series_start,
  input  wire logic signed [SAMPLE_WIDTH-1:0] wr_data,
  input  wire logic        [IW-1:0]           rd_addr,
  output logic signed      [SAMPLE_WIDTH-1:0] rd_data,
  output win_stat_t                           stat
);

  logic signed [SAMPLE_WIDTH-1:0] store_r [MAX_WINDOW];
  logic [CW-1:0] fill_r;
  logic [IW-1:0] wp_r;
  logic [CW-1:0] fill_eff;
  logic [IW-1:0] wp_eff;

  always_comb begin
    fill_eff = series_start ? '0 : fill_r;
    wp_eff   = series_start ? '0 : wp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      wp_r   <= '0;
    end else if (wr_en) begin
      wp_r   <= (wp_eff == IW'(MAX_WINDOW - 1)) ? '0 : wp_eff + 1'b1;
      fill_r <= (fill_eff < CW'(MAX_WINDOW)) ? fill_eff + 1'b1 : fill_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wp_eff] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= store_r[rd_addr];
  end

  assign stat.fill = fill_r;
  assign stat.wp   = wp_r;

endmodule
`default_nettype wire

// ===== rtl/core/slr_muldiv.sv =====
`default_nettype none
module slr_muldiv
  import slr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire md_req_t          req,
  input  wire logic [ALU_W-1:0] opa,
  input  wire logic [ALU_W-1:0] opb,
  output logic      [ALU_W-1:0] result,
  output logic                  busy
);

  // mul: acc += a when b[0]; a <<= 1; b >>= 1
  // div: a holds the pre-shifted divisor; b collects quotient bits
  logic [ALU_W-1:0] acc_r, a_r, b_r;
  logic [NB_W-1:0]  cnt_r;
  md_op_t           op_r;
  logic             busy_r;
  logic [ALU_W-1:0] addend;
  logic [ALU_W:0]   sum_c;
  logic             ge;

  always_comb begin
    addend = (op_r == MD_DIV) ? ~a_r : a_r;
    sum_c  = {1'b0, acc_r} + {1'b0, addend} + (ALU_W+1)'(op_r == MD_DIV);
    ge     = sum_c[ALU_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == NB_W'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      cnt_r <= req.nbits;
      unique case (req.op)
        MD_MUL: begin
          acc_r <= '0;
          a_r   <= opa;
          b_r   <= opb;
        end
        MD_DIV: begin
          acc_r <= opa;
          a_r   <= opb;
          b_r   <= '0;
        end
      endcase
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      unique case (op_r)
        MD_MUL: begin
          if (b_r[0]) acc_r <= sum_c[ALU_W-1:0];
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end
        MD_DIV: begin
          if (ge) acc_r <= sum_c[ALU_W-1:0];
          a_r <= a_r >> 1;
          b_r <= {b_r[ALU_W-2:0], ge};
        end
      endcase
    end
  end

  assign result = (op_r == MD_MUL) ? acc_r : b_r;
  assign busy   = busy_r;

endmodule
`default_nettype wire

// ===== rtl/core/sliding_linear_regression.sv =====
// Sliding-window least-squares line fit. Each item carries one signed
// Q16.16 sample; the block keeps the last window_len samples (at most 64)
// and returns one result item per input item: slope per sample (Q16.16,
// truncated toward zero, saturated), r squared (Q1.16, 65536 = 1.0) and the
// largest absolute residual over the magnitude of the window mean (Q16.16,
// saturated). The oldest held sample sits at x = 0. series_start empties the
// window before its sample is taken. The first sample of a series gives an
// all-zero result; a window length of 0 or 1 gives valid_res alone.
// degenerate flags a flat window (r squared 0) or a zero mean (residual 0).
// Each item takes two passes over the window store at one read a cycle, plus
// the shift-add multiplies and restoring divides that run one bit a cycle on
// the single shared 124-bit multiply/divide unit. A flat window skips the r
// squared steps; a zero mean or a saturating ratio skips the last divide.
// Only the early-out cases (fewer than two samples, short window) skip the
// passes and the unit. in_stall is low only while the sequencer is idle; a
// finished result waits in the output register without holding off the next
// item. window_len is written through cfg_wr_en/cfg_wr_data, by the user only
// while idle; the block itself does not enforce it.
`default_nettype none
`include "sliding_linear_regression_assert.svh"
module sliding_linear_regression
  import slr_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input item channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                           in_series_start,
  // result item channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed      [OUT_W-1:0]        out_slope,
  output logic             [R2_W-1:0]         out_r_squared,
  output logic             [OUT_W-1:0]        out_rel_max_residual,
  output logic                                out_valid_res,
  output logic                                out_degenerate,
  // configuration
  input  wire logic                           cfg_wr_en,
  input  wire logic        [WLEN_W-1:0]       cfg_wr_data
);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  state_t state_r, state_nxt;

  logic [WLEN_W-1:0] wlen_r;

  // window store
  logic                           win_wr;
  logic signed [SAMPLE_WIDTH-1:0] rd_data;
  win_stat_t                      win_stat;

  // shared multiply/divide unit
  md_req_t          md_req;
  logic [ALU_W-1:0] md_opa, md_opb, md_result;
  logic             md_busy;

  // sequencer datapath
  logic [CW-1:0]               c_r;
  logic [IW-1:0]               base_r, rd_ptr_r;
  logic [CW-1:0]               iss_r, pj_r;
  logic                        pv_r;
  logic signed [SUMY_W-1:0]    sum_y_r;
  logic signed [SUMXY_W-1:0]   sum_xy_r;
  logic        [SUMYY_W-1:0]   sum_yy_r;
  logic signed [SXYC_W-1:0]    cxy_r, sxyc_r;
  logic        [ALU_W-1:0]     num_r;
  logic        [SYYC_W-1:0]    syyc_r;
  logic signed [T_W-1:0]       term_r, sc_r;
  logic        [T_W-1:0]       maxabs_r;

  // result registers
  logic signed [OUT_W-1:0] slope_r;
  logic [R2_W-1:0]         r2_r;
  logic [OUT_W-1:0]        rel_r;
  logic                    vres_r, degen_r;

  // output register
  logic                    out_valid_r;
  logic                    out_load;

  // combinational helpers
  logic [CW-1:0]             n_c, c_c;
  logic [CW:0]               wpx;
  logic [IW-1:0]             base_c, ptr_inc;
  logic                      issue;
  logic [SXYC_W-1:0]         sxyc_mag;
  logic [SUMY_W-1:0]         sy_mag;
  logic [SL_Q-1:0]           q_sl;
  logic signed [OUT_W-1:0]   slope_c;
  logic [SYYC_W-1:0]         syyc_c;
  logic signed [SUMXY_W-1:0] jy_c;
  logic signed [2*SAMPLE_WIDTH-1:0] sq_c;
  logic signed [T_W-1:0]     t_c;
  logic        [T_W-1:0]     at_c;
  logic                      res_sat;

  slr_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (win_wr),
    .series_start (in_series_start),
    .wr_data      (in_sample),
    .rd_addr      (rd_ptr_r),
    .rd_data      (rd_data),
    .stat         (win_stat)
  );

  slr_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .opa    (md_opa),
    .opb    (md_opb),
    .result (md_result),
    .busy   (md_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RESET;
    end else if (cfg_wr_en) begin
      wlen_r <= cfg_wr_data;
    end
  end

  // window geometry after the new sample went in
  always_comb begin
    n_c = (int'(wlen_r) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(wlen_r);
    c_c = (win_stat.fill < n_c) ? win_stat.fill : n_c;
    wpx = (CW+1)'(win_stat.wp);
    if (wpx >= (CW+1)'(c_c)) begin
      base_c = IW'(wpx - (CW+1)'(c_c));
    end else begin
      base_c = IW'(wpx + (CW+1)'(MAX_WINDOW) - (CW+1)'(c_c));
    end
    ptr_inc = (rd_ptr_r == IW'(MAX_WINDOW - 1)) ? '0 : rd_ptr_r + 1'b1;
  end

  // arithmetic helpers
  always_comb begin
    sxyc_mag = sxyc_r[SXYC_W-1] ? SXYC_W'(-sxyc_r) : SXYC_W'(sxyc_r);
    sy_mag   = sum_y_r[SUMY_W-1] ? SUMY_W'(-sum_y_r) : SUMY_W'(sum_y_r);
    q_sl     = md_result[SL_Q-1:0];
    if (sxyc_r[SXYC_W-1]) begin
      slope_c = (q_sl > (SL_Q'(1) << (OUT_W - 1))) ? OUT_MIN : OUT_W'(SL_Q'(0) - q_sl);
    end else begin
      slope_c = (q_sl > SL_Q'(OUT_MAX)) ? OUT_MAX : OUT_W'(q_sl);
    end
    syyc_c  = SYYC_W'(c_r * sum_yy_r) - SYYC_W'(md_result);
    jy_c    = SUMXY_W'($signed({1'b0, pj_r}) * rd_data);
    sq_c    = (2*SAMPLE_WIDTH)'(rd_data * rd_data);
    t_c     = T_W'($signed({1'b0, c_r}) * rd_data) - T_W'(sum_y_r) - term_r;
    at_c    = t_c[T_W-1] ? T_W'(-t_c) : T_W'(t_c);
    res_sat = ALU_W'(maxabs_r) >= (ALU_W'(sy_mag) << (OUT_W - FRAC_BITS));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_SETUP;
      S_SETUP: begin
        if (win_stat.fill < CW'(2) || n_c < CW'(2)) state_nxt = S_DONE;
        else                                        state_nxt = S_ACC;
      end
      S_ACC:     if (iss_r == c_r && !pv_r) state_nxt = S_SXYC;
      S_SXYC:    state_nxt = S_SXYC2;
      S_SXYC2:   state_nxt = S_SLOPE;
      S_SLOPE:   state_nxt = S_SLOPE_W;
      S_SLOPE_W: if (!md_busy) state_nxt = S_NUM;
      S_NUM:     state_nxt = S_NUM_W;
      S_NUM_W:   if (!md_busy) state_nxt = S_SY2;
      S_SY2:     state_nxt = S_SY2_W;
      S_SY2_W:   if (!md_busy) state_nxt = S_SYYC;
      S_SYYC:    state_nxt = (syyc_c == '0) ? S_RINIT : S_DEN;
      S_DEN:     state_nxt = S_DEN_W;
      S_DEN_W:   if (!md_busy) state_nxt = S_R2;
      S_R2:      state_nxt = S_R2_W;
      S_R2_W:    if (!md_busy) state_nxt = S_RINIT;
      S_RINIT:   state_nxt = S_RES;
      S_RES:     if (iss_r == c_r && !pv_r) state_nxt = S_RCHK;
      S_RCHK: begin
        if (sy_mag == '0 || res_sat) state_nxt = S_DONE;
        else                         state_nxt = S_RDIV;
      end
      S_RDIV:    state_nxt = S_RDIV_W;
      S_RDIV_W:  if (!md_busy) state_nxt = S_DONE;
      S_DONE:    if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall     = (state_r != S_IDLE);
    win_wr       = (state_r == S_IDLE) && in_valid;
    issue        = (state_r == S_ACC || state_r == S_RES) && (iss_r < c_r);
    out_load     = (state_r == S_DONE) && (!out_valid_r || !out_stall);
    md_req.start = 1'b0;
    md_req.op    = MD_MUL;
    md_req.nbits = '0;
    md_opa       = '0;
    md_opb       = '0;
    unique case (state_r)
      S_SLOPE: begin
        md_req = '{start: 1'b1, op: MD_DIV, nbits: NB_W'(SL_Q)};
        md_opa = ALU_W'(sxyc_mag);
        md_opb = ALU_W'(D_TAB[c_r]) << (SL_Q - 1);
      end
      S_NUM: begin
        md_req = '{start: 1'b1, op: MD_MUL, nbits: NB_W'(SL_Q)};
        md_opa = ALU_W'(sxyc_mag);
        md_opb = ALU_W'(sxyc_mag);
      end
      S_SY2: begin
        md_req = '{start: 1'b1, op: MD_MUL, nbits: NB_W'(SUMY_W)};
        md_opa = ALU_W'(sy_mag);
        md_opb = ALU_W'(sy_mag);
      end
      S_DEN: begin
        md_req = '{start: 1'b1, op: MD_MUL, nbits: NB_W'(D_W)};
        md_opa = ALU_W'(syyc_r);
        md_opb = ALU_W'(D_TAB[c_r]);
      end
      S_R2: begin
        md_req = '{start: 1'b1, op: MD_DIV, nbits: NB_W'(R2_W)};
        md_opa = num_r << R2_FRAC;
        md_opb = md_result << R2_FRAC;
      end
      S_RDIV: begin
        md_req = '{start: 1'b1, op: MD_DIV, nbits: NB_W'(OUT_W)};
        md_opa = ALU_W'(maxabs_r) << FRAC_BITS;
        md_opb = ALU_W'(sy_mag) << (OUT_W - 1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= issue;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ptr_r <= ptr_inc;
      iss_r    <= iss_r + 1'b1;
      pj_r     <= iss_r;
    end
    unique case (state_r)
      S_SETUP: begin
        c_r      <= c_c;
        base_r   <= base_c;
        rd_ptr_r <= base_c;
        iss_r    <= '0;
        sum_y_r  <= '0;
        sum_xy_r <= '0;
        sum_yy_r <= '0;
        slope_r  <= '0;
        r2_r     <= '0;
        rel_r    <= '0;
        degen_r  <= 1'b0;
        vres_r   <= (win_stat.fill >= CW'(2));
      end
      S_ACC: begin
        if (pv_r) begin
          sum_y_r  <= sum_y_r + SUMY_W'(rd_data);
          sum_xy_r <= sum_xy_r + jy_c;
          sum_yy_r <= sum_yy_r + SUMYY_W'($unsigned(sq_c));
        end
      end
      S_SXYC:  cxy_r  <= SXYC_W'($signed({1'b0, c_r}) * sum_xy_r);
      S_SXYC2: sxyc_r <= cxy_r - SXYC_W'($signed({1'b0, SX_TAB[c_r]}) * sum_y_r);
      S_SLOPE_W: if (!md_busy) slope_r <= slope_c;
      S_NUM:   sc_r <= T_W'(slope_r * $signed({1'b0, c_r}));
      S_NUM_W: if (!md_busy) num_r <= md_result;
      S_SYYC: begin
        syyc_r <= syyc_c;
        // flat window: no spread in y
        if (syyc_c == '0) degen_r <= 1'b1;
      end
      S_R2_W: begin
        if (!md_busy) begin
          r2_r <= (md_result[R2_W-1:0] > R2_ONE) ? R2_ONE : md_result[R2_W-1:0];
        end
      end
      S_RINIT: begin
        rd_ptr_r <= base_r;
        iss_r    <= '0;
        maxabs_r <= '0;
        term_r   <= T_W'(-(slope_r * $signed({1'b0, SX_TAB[c_r]})));
      end
      S_RES: begin
        if (pv_r) begin
          term_r <= term_r + sc_r;
          if (at_c > maxabs_r) maxabs_r <= at_c;
        end
      end
      S_RCHK: begin
        // zero mean gives no relative residual
        if (sy_mag == '0)  degen_r <= 1'b1;
        else if (res_sat)  rel_r   <= '1;
      end
      S_RDIV_W: if (!md_busy) rel_r <= md_result[OUT_W-1:0];
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slope            <= slope_r;
      out_r_squared        <= r2_r;
      out_rel_max_residual <= rel_r;
      out_valid_res        <= vres_r;
      out_degenerate       <= degen_r;
    end
  end

  assign out_valid = out_valid_r;

  `SLR_ASSERT(a_md_start_idle, md_req.start |-> !md_busy, "muldiv started while busy")
  `SLR_ASSERT_NEXT(a_md_runs, md_req.start, md_busy, "muldiv did not go busy")
  `SLR_ASSERT(a_r2_range, out_valid_r |-> (out_r_squared <= R2_ONE), "r squared above one")
  `SLR_ASSERT(a_degen_valid, (out_valid_r && out_degenerate) |-> out_valid_res, "degenerate without valid")
  `SLR_ASSERT(a_c_range, (state_r == S_ACC) |-> (c_r >= CW'(2) && c_r <= win_stat.fill), "bad window count")

endmodule
`default_nettype wire
